FILE: rtl/u2pu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2pu_pkg: shared types and constants for the UTF-8 to %u escape unit
// Holds the work descriptor that the front end hands to the back end, the
// queue status group, the escape characters and the code point limits.
// ----------------------------------------------------------------------------
package u2pu_pkg;

  // Queue between front and back end.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  // Characters of the escape.
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_A_LOWER = 8'h61;

  // Code point limits.
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] MIN_FOUR  = 21'h010000;
  localparam logic [20:0] MIN_THREE = 21'h000800;
  localparam logic [20:0] MIN_TWO   = 21'h000080;
  localparam logic [20:0] MAX_FOUR_DIGITS = 21'h00FFFF;
  localparam logic [20:0] MAX_FIVE_DIGITS = 21'h0FFFFF;

  // Byte classes.
  localparam logic [7:0] LEAD_ECHO_MIN = 8'hF5;

  // One request worth of output, in emission order:
  // flushed continuations, then a raw byte or an escape with repeats.
  typedef struct packed {
    logic [1:0]  flush_cnt;
    logic [7:0]  flush0;
    logic [7:0]  flush1;
    logic        raw_v;
    logic [7:0]  raw_b;
    logic        esc_v;
    logic [20:0] cp;
    logic [2:0]  hex_top;
    logic [1:0]  rep_cnt;
    logic [7:0]  lead;
    logic        last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/utf8_to_percent_u_escape_unit.sv
`timescale 1ns / 1ps
// A request passes through a queue entry, the descriptor register and the
// output register before its first character appears. The serializer emits
// one character per cycle while out_stall is low, and pops a new request only
// once it is done with the last. The front end takes a new byte whenever the
// two-entry queue has room. Reset (rst_n low, synchronous) closes any open
// sequence and empties the queue and output register.
// ----------------------------------------------------------------------------
// utf8_to_percent_u_escape_unit: UTF-8 to %u escape converter
// Classifier front end, descriptor queue and character serializer back end.
// ----------------------------------------------------------------------------
module utf8_to_percent_u_escape_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_has_char,
  output logic       out_last
);
  import u2pu_pkg::*;

  job_t      front_job, head_job;
  q_status_t q_status;
  logic      take, q_pop;

  // A request is taken whenever the queue has a free entry.
  assign in_stall = q_status.full;
  assign take     = in_valid && !q_status.full;

  u2pu_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .job              (front_job)
  );

  u2pu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (take),
    .push_job (front_job),
    .pop      (q_pop),
    .pop_job  (head_job),
    .status   (q_status)
  );

  u2pu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_status     (q_status),
    .q_job        (head_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_has_char (out_has_char),
    .out_last     (out_last)
  );

endmodule

FILE: rtl/u2pu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2pu_front: byte classifier and sequence assembler
// Tracks the open UTF-8 sequence and turns each accepted request into one
// work descriptor for the back end.
// ----------------------------------------------------------------------------
module u2pu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_string,
  output u2pu_pkg::job_t    job
);
  import u2pu_pkg::*;

  logic [7:0] held0_r, held1_r, held2_r;
  logic [7:0] held0_nxt, held1_nxt, held2_nxt;
  logic [1:0] held_count_r, held_count_nxt;
  logic [2:0] exp_len_r, exp_len_nxt;

  logic        do_fresh;
  logic [20:0] cp;
  logic        surr, over;

  // Code point of a sequence completed by the current byte.
  always_comb begin
    case (exp_len_r)
      3'd2:    cp = {10'd0, held0_r[4:0], in_byte[5:0]};
      3'd3:    cp = {5'd0, held0_r[3:0], held1_r[5:0], in_byte[5:0]};
      default: cp = {held0_r[2:0], held1_r[5:0], held2_r[5:0], in_byte[5:0]};
    endcase
    surr = (cp >= SURR_LO) && (cp <= SURR_HI);
    over = ((exp_len_r == 3'd4) && (cp < MIN_FOUR)) ||
           ((exp_len_r == 3'd3) && (cp < MIN_THREE)) ||
           ((exp_len_r == 3'd2) && (cp < MIN_TWO));
  end

  // Classification and next sequence state.
  always_comb begin
    job            = '0;
    do_fresh       = 1'b0;
    held0_nxt      = held0_r;
    held1_nxt      = held1_r;
    held2_nxt      = held2_r;
    held_count_nxt = held_count_r;
    exp_len_nxt    = exp_len_r;

    if (held_count_r == 2'd0) begin
      do_fresh = 1'b1;
    end else if (in_byte[7:6] == 2'b10) begin
      if (({1'b0, held_count_r} + 3'd1) >= exp_len_r) begin
        // Sequence complete: build the escape.
        job.esc_v   = 1'b1;
        job.cp      = cp;
        job.lead    = held0_r;
        job.hex_top = (cp > MAX_FIVE_DIGITS) ? 3'd5 :
                      (cp > MAX_FOUR_DIGITS) ? 3'd4 : 3'd3;
        job.rep_cnt = {1'b0, surr} + {1'b0, over};
        held_count_nxt = 2'd0;
        exp_len_nxt    = 3'd0;
      end else begin
        if (held_count_r == 2'd1) held1_nxt = in_byte;
        if (held_count_r == 2'd2) held2_nxt = in_byte;
        held_count_nxt = held_count_r + 2'd1;
      end
    end else begin
      // Bad continuation: drop the lead, emit held continuations raw.
      job.flush_cnt  = held_count_r - 2'd1;
      job.flush0     = held1_r;
      job.flush1     = held2_r;
      held_count_nxt = 2'd0;
      exp_len_nxt    = 3'd0;
      do_fresh       = 1'b1;
    end

    // A byte examined with no sequence open.
    job.raw_b = in_byte;
    if (do_fresh) begin
      if (in_byte[7] == 1'b0) begin
        job.raw_v = (in_byte != 8'h00);
      end else if (in_byte[7:5] == 3'b110) begin
        held0_nxt = in_byte; held_count_nxt = 2'd1; exp_len_nxt = 3'd2;
      end else if (in_byte[7:4] == 4'b1110) begin
        held0_nxt = in_byte; held_count_nxt = 2'd1; exp_len_nxt = 3'd3;
      end else if (in_byte[7:3] == 5'b11110) begin
        job.raw_v = (in_byte >= LEAD_ECHO_MIN);
        held0_nxt = in_byte; held_count_nxt = 2'd1; exp_len_nxt = 3'd4;
      end else begin
        job.raw_v = 1'b1;
      end
    end

    // End of string closes any open sequence as invalid. A lone lead has no
    // continuations to flush, so any flush already set up stays in place.
    if (in_end_of_string) begin
      if (held_count_nxt > 2'd1) begin
        job.flush_cnt  = held_count_nxt - 2'd1;
        job.flush0     = held1_nxt;
        job.flush1     = held2_nxt;
      end
      held_count_nxt = 2'd0;
      exp_len_nxt    = 3'd0;
      job.last = 1'b1;
    end
  end

  // Held bytes carry payload only.
  always_ff @(posedge clk) begin
    if (take) begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      held2_r <= held2_nxt;
    end
  end

  // Sequence control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= 2'd0;
      exp_len_r    <= 3'd0;
    end else if (take) begin
      held_count_r <= held_count_nxt;
      exp_len_r    <= exp_len_nxt;
    end
  end

endmodule

FILE: rtl/u2pu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2pu_queue: short descriptor queue
// Two-entry FIFO that decouples the classifier from the serializer.
// ----------------------------------------------------------------------------
module u2pu_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  u2pu_pkg::job_t       push_job,
  input  logic                 pop,
  output u2pu_pkg::job_t       pop_job,
  output u2pu_pkg::q_status_t  status
);
  import u2pu_pkg::*;

  job_t            entry_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;

  assign status.full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_job      = entry_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: rtl/u2pu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2pu_back: output serializer
// Walks one descriptor at a time and emits its characters into an output
// register, one character per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
module u2pu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  u2pu_pkg::q_status_t  q_status,
  input  u2pu_pkg::job_t       q_job,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_char,
  output logic                 out_has_char,
  output logic                 out_last
);
  import u2pu_pkg::*;

  typedef enum logic [3:0] {
    PH_FLUSH0 = 4'd0,
    PH_FLUSH1 = 4'd1,
    PH_RAW    = 4'd2,
    PH_PCT    = 4'd3,
    PH_U      = 4'd4,
    PH_HEX    = 4'd5,
    PH_REP    = 4'd6,
    PH_BARE   = 4'd7,
    PH_DONE   = 4'd8
  } phase_t;

  // First phase at or after p that has work in descriptor j.
  function automatic phase_t seek(input phase_t p, input job_t j);
    phase_t r;
    r = PH_DONE;
    if ((p <= PH_REP) && (j.rep_cnt != 2'd0))  r = PH_REP;
    if ((p <= PH_HEX) && j.esc_v)              r = PH_HEX;
    if ((p <= PH_U) && j.esc_v)                r = PH_U;
    if ((p <= PH_PCT) && j.esc_v)              r = PH_PCT;
    if ((p <= PH_RAW) && j.raw_v)              r = PH_RAW;
    if ((p <= PH_FLUSH1) && (j.flush_cnt >= 2'd2)) r = PH_FLUSH1;
    if ((p <= PH_FLUSH0) && (j.flush_cnt >= 2'd1)) r = PH_FLUSH0;
    return r;
  endfunction

  job_t       job_r;
  phase_t     phase_r, phase_nxt, load_phase, start_phase;
  logic [2:0] cnt_r, cnt_nxt, load_cnt;
  logic       slot_free, emit;
  logic [7:0] char_nxt;
  logic [3:0] nibble;
  logic [23:0] cp_wide;

  assign slot_free = !out_valid || !out_stall;
  assign emit      = (phase_r != PH_DONE) && slot_free;
  assign q_pop     = (phase_r == PH_DONE) && !q_status.empty;
  assign cp_wide   = {3'd0, job_r.cp};

  // Hex digit currently selected.
  always_comb begin
    case (cnt_r)
      3'd0:    nibble = cp_wide[3:0];
      3'd1:    nibble = cp_wide[7:4];
      3'd2:    nibble = cp_wide[11:8];
      3'd3:    nibble = cp_wide[15:12];
      3'd4:    nibble = cp_wide[19:16];
      default: nibble = cp_wide[23:20];
    endcase
  end

  // Character of the current phase.
  always_comb begin
    case (phase_r)
      PH_FLUSH0: char_nxt = job_r.flush0;
      PH_FLUSH1: char_nxt = job_r.flush1;
      PH_RAW:    char_nxt = job_r.raw_b;
      PH_PCT:    char_nxt = CH_PERCENT;
      PH_U:      char_nxt = CH_U;
      PH_HEX:    char_nxt = (nibble < 4'd10) ? (CH_ZERO + {4'd0, nibble})
                                             : (CH_A_LOWER + {4'd0, nibble} - 8'd10);
      PH_REP:    char_nxt = job_r.lead;
      default:   char_nxt = 8'h00;
    endcase
  end

  // Phase sequencing within a descriptor.
  always_comb begin
    cnt_nxt = cnt_r;
    if ((phase_r == PH_HEX) && (cnt_r != 3'd0)) begin
      phase_nxt = PH_HEX;
      cnt_nxt   = cnt_r - 3'd1;
    end else if ((phase_r == PH_REP) && (cnt_r > 3'd1)) begin
      phase_nxt = PH_REP;
      cnt_nxt   = cnt_r - 3'd1;
    end else if (phase_r == PH_DONE) begin
      phase_nxt = PH_DONE;
    end else begin
      phase_nxt = seek(phase_t'(phase_r + 4'd1), job_r);
      cnt_nxt   = (phase_nxt == PH_HEX) ? job_r.hex_top : {1'b0, job_r.rep_cnt};
    end
  end

  // Starting point of a freshly popped descriptor.
  always_comb begin
    start_phase = seek(PH_FLUSH0, q_job);
    if (start_phase == PH_DONE) begin
      load_phase = q_job.last ? PH_BARE : PH_DONE;
    end else begin
      load_phase = start_phase;
    end
    load_cnt = (start_phase == PH_HEX) ? q_job.hex_top : {1'b0, q_job.rep_cnt};
  end

  // Descriptor payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
  end

  // Sequencer state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DONE;
      cnt_r        <= 3'd0;
      out_valid    <= 1'b0;
      out_char     <= 8'h00;
      out_has_char <= 1'b0;
      out_last     <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= load_phase;
        cnt_r   <= load_cnt;
      end else if (emit) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (emit) begin
        out_valid    <= 1'b1;
        out_char     <= char_nxt;
        out_has_char <= (phase_r != PH_BARE);
        out_last     <= job_r.last && (phase_nxt == PH_DONE);
      end else if (slot_free) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: UTF-8 to %u escape unit
// A directed table and then random byte streams go into the unit. A model of
// the converter in this file predicts the characters of each untyped request,
// and each character that leaves the unit is checked against the oldest one
// still expected, under changing sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import u2pu_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;
  localparam int ITEMS_PER_PHASE = 60;

  // Kinds of random bursts.
  typedef enum int {
    BURST_ASCII,
    BURST_SEQUENCE,
    BURST_BROKEN,
    BURST_ANY,
    BURST_STRAY
  } burst_kind_t;

  // One output character as the unit presents it.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_ch;
    logic       last;
  } char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       out_has_char;
  logic       out_last;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Characters still owed by the unit, oldest first.
  char_t expected_chars[$];

  // Converter state: the open sequence.
  logic [7:0] seq_bytes [3];
  logic [1:0] seq_held = 2'd0;
  logic [2:0] seq_len = 3'd0;
  char_t      step_chars[$];

  // Directed table.
  logic [7:0] row_byte[$];
  logic       row_eos[$];
  bit         row_typed[$];
  string      row_chars[$];

  utf8_to_percent_u_escape_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_has_char     (out_has_char),
    .out_last         (out_last)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- converter

  task automatic emit_char(input logic [7:0] c);
    char_t item;
    item.ch = c;
    item.has_ch = 1'b1;
    item.last = 1'b0;
    step_chars.push_back(item);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + {4'h0, n};
    return CH_A_LOWER + {4'h0, n} - 8'd10;
  endfunction

  // A byte seen with no sequence open.
  task automatic take_fresh_byte(input logic [7:0] b);
    if (b < 8'h80) begin
      if (b != 8'h00) emit_char(b);
    end else if ((b & 8'hE0) == 8'hC0) begin
      seq_bytes[0] = b;
      seq_held = 2'd1;
      seq_len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      seq_bytes[0] = b;
      seq_held = 2'd1;
      seq_len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      // Leads past the Unicode range are echoed before they are held.
      if (b >= LEAD_ECHO_MIN) emit_char(b);
      seq_bytes[0] = b;
      seq_held = 2'd1;
      seq_len = 3'd4;
    end else begin
      emit_char(b);
    end
  endtask

  // An invalid sequence loses its lead; held continuations go out raw.
  task automatic flush_continuations();
    for (int k = 1; k < seq_held; k++) emit_char(seq_bytes[k]);
    seq_held = 2'd0;
    seq_len = 3'd0;
  endtask

  task automatic emit_escape(input logic [7:0] last_b);
    logic [7:0]  lead;
    logic [23:0] cp;
    int          digits;
    lead = seq_bytes[0];
    case (seq_len)
      3'd2: cp = {13'd0, lead[4:0], last_b[5:0]};
      3'd3: cp = {8'd0, lead[3:0], seq_bytes[1][5:0], last_b[5:0]};
      default: cp = {3'd0, lead[2:0], seq_bytes[1][5:0], seq_bytes[2][5:0], last_b[5:0]};
    endcase
    emit_char(CH_PERCENT);
    emit_char(CH_U);
    digits = 4;
    if (cp > MAX_FOUR_DIGITS) digits = 5;
    if (cp > MAX_FIVE_DIGITS) digits = 6;
    for (int k = digits - 1; k >= 0; k--) emit_char(hex_char(cp[4*k +: 4]));
    // Surrogate first, then overlong form, each repeats the lead.
    if (cp >= SURR_LO && cp <= SURR_HI) emit_char(lead);
    if ((seq_len == 3'd4 && cp < MIN_FOUR) || (seq_len == 3'd3 && cp < MIN_THREE) ||
        (seq_len == 3'd2 && cp < MIN_TWO)) begin
      emit_char(lead);
    end
    seq_held = 2'd0;
    seq_len = 3'd0;
  endtask

  // Characters caused by one accepted request, left in step_chars.
  task automatic convert_byte(input logic [7:0] b, input logic eos);
    char_t item;
    step_chars.delete();
    if (seq_held == 2'd0) begin
      take_fresh_byte(b);
    end else if ((b & 8'hC0) == 8'h80) begin
      if ({1'b0, seq_held} + 3'd1 >= seq_len) begin
        emit_escape(b);
      end else begin
        seq_bytes[seq_held] = b;
        seq_held = seq_held + 2'd1;
      end
    end else begin
      flush_continuations();
      take_fresh_byte(b);
    end
    if (eos) begin
      // A sequence cut off by the end of the string is invalid.
      if (seq_held != 2'd0) flush_continuations();
      if (step_chars.size() == 0) begin
        item.ch = 8'h00;
        item.has_ch = 1'b0;
        item.last = 1'b1;
      end else begin
        item = step_chars.pop_back();
        item.last = 1'b1;
      end
      step_chars.push_back(item);
    end
  endtask

  // ------------------------------------------------------------------ driving

  // Offers one request and books its characters once it is accepted. A typed
  // row supplies its characters directly; the converter still advances.
  task automatic send_byte(input logic [7:0] b, input logic eos, input bit typed,
                           input string typed_chars);
    char_t item;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_string <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    convert_byte(b, eos);
    if (typed) begin
      for (int i = 0; i < typed_chars.len(); i++) begin
        item.ch = typed_chars[i];
        item.has_ch = 1'b1;
        item.last = eos && (i == typed_chars.len() - 1);
        expected_chars.push_back(item);
      end
      if (typed_chars.len() == 0 && eos) begin
        item.ch = 8'h00;
        item.has_ch = 1'b0;
        item.last = 1'b1;
        expected_chars.push_back(item);
      end
    end else begin
      foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
    end
  endtask

  task automatic add_row(input logic [7:0] b, input logic eos, input bit typed,
                         input string typed_chars);
    row_byte.push_back(b);
    row_eos.push_back(eos);
    row_typed.push_back(typed);
    row_chars.push_back(typed_chars);
  endtask

  // Lead byte of a given length; corner leads favor overlong, surrogate and
  // out-of-range code points.
  function automatic logic [7:0] pick_lead(input int len, input bit corner);
    if (len == 2) return corner ? (8'hC0 | 8'($urandom_range(0, 1)))
                                : (8'hC0 | 8'($urandom_range(0, 31)));
    if (len == 3) begin
      if (corner) return ($urandom_range(0, 1) == 0) ? 8'hE0 : 8'hED;
      return 8'hE0 | 8'($urandom_range(0, 15));
    end
    if (corner) begin
      case ($urandom_range(0, 3))
        0: return 8'hF0;
        1: return 8'hF4;
        2: return 8'hF5;
        default: return 8'hF7;
      endcase
    end
    return 8'hF0 | 8'($urandom_range(0, 7));
  endfunction

  // The receiver stalls at random.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // ----------------------------------------------------------------- checking

  always @(posedge clk) begin
    char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character %h (has_char %b, last %b)", out_char, out_has_char,
               out_last);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, out_char);
          mismatches++;
        end
        if (out_has_char !== want.has_ch) begin
          $error("out_has_char: expected %b, got %b", want.has_ch, out_has_char);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any request or character moving.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ----------------------------------------------------------------- stimulus

  initial begin : stimulus
    logic [7:0]  burst[$];
    logic [7:0]  b;
    burst_kind_t kind;
    int          pick;
    int          len;
    int          conts;
    int          sent;
    bit          corner;
    logic        eos;

    seq_bytes[0] = 8'h00;
    seq_bytes[1] = 8'h00;
    seq_bytes[2] = 8'h00;

    // Plain bytes, dropped NUL, stray and invalid bytes, bare end marker.
    add_row(8'h41, 1'b0, 1'b1, "A");
    add_row(8'h00, 1'b0, 1'b1, "");
    add_row(8'h7F, 1'b0, 1'b1, "\177");
    add_row(8'h80, 1'b0, 1'b1, "\200");
    add_row(8'hFF, 1'b1, 1'b1, "\377");
    add_row(8'h00, 1'b1, 1'b1, "");
    // Overlong 2-byte form.
    add_row(8'hC0, 1'b0, 1'b0, "");
    add_row(8'h80, 1'b0, 1'b0, "");
    // Overlong 3-byte form.
    add_row(8'hE0, 1'b0, 1'b0, "");
    add_row(8'h80, 1'b0, 1'b0, "");
    add_row(8'h80, 1'b0, 1'b0, "");
    // Surrogate.
    add_row(8'hED, 1'b0, 1'b0, "");
    add_row(8'hA0, 1'b0, 1'b0, "");
    add_row(8'h80, 1'b0, 1'b0, "");
    // Surrogate reached through an overlong 4-byte form.
    add_row(8'hF0, 1'b0, 1'b0, "");
    add_row(8'h8D, 1'b0, 1'b0, "");
    add_row(8'hA0, 1'b0, 1'b0, "");
    add_row(8'h80, 1'b0, 1'b0, "");
    // Echoed high lead with the largest code point, closing the string.
    add_row(8'hF7, 1'b0, 1'b0, "");
    add_row(8'hBF, 1'b0, 1'b0, "");
    add_row(8'hBF, 1'b0, 1'b0, "");
    add_row(8'hBF, 1'b1, 1'b0, "");
    // Bad continuation: the new lead is examined afresh and completes.
    add_row(8'hE2, 1'b0, 1'b0, "");
    add_row(8'h82, 1'b0, 1'b0, "");
    add_row(8'hC3, 1'b0, 1'b0, "");
    add_row(8'hA9, 1'b1, 1'b0, "");
    // Bad continuation whose new lead is cut off by the end of the string.
    add_row(8'hF0, 1'b0, 1'b0, "");
    add_row(8'h90, 1'b0, 1'b0, "");
    add_row(8'h91, 1'b0, 1'b0, "");
    add_row(8'hF6, 1'b1, 1'b0, "");
    // Sequence cut off by the end of the string.
    add_row(8'hE2, 1'b0, 1'b0, "");
    add_row(8'h82, 1'b1, 1'b1, "\202");

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_stall_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_stall_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase

      if (phase == 0) begin
        foreach (row_byte[i]) send_byte(row_byte[i], row_eos[i], row_typed[i], row_chars[i]);
      end

      // Mostly well-formed sequences with random content, some noise.
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) kind = BURST_ASCII;
        else if (pick < 70) kind = BURST_SEQUENCE;
        else if (pick < 82) kind = BURST_BROKEN;
        else if (pick < 92) kind = BURST_ANY;
        else kind = BURST_STRAY;

        burst.delete();
        case (kind)
          BURST_ASCII: burst.push_back(8'($urandom_range(0, 127)));
          BURST_ANY: burst.push_back(8'($urandom_range(0, 255)));
          BURST_STRAY: begin
            if ($urandom_range(0, 1) == 0) burst.push_back(8'h80 | 8'($urandom_range(0, 63)));
            else burst.push_back(8'hF8 | 8'($urandom_range(0, 7)));
          end
          default: begin
            len = $urandom_range(2, 4);
            corner = ($urandom_range(0, 3) == 0);
            b = pick_lead(len, corner);
            burst.push_back(b);
            conts = (kind == BURST_SEQUENCE) ? len - 1 : $urandom_range(0, len - 2);
            for (int k = 0; k < conts; k++) begin
              if (corner && k == 0 && (b == 8'hE0 || b == 8'hF0 || b == 8'hF4)) begin
                burst.push_back(8'h80 | 8'($urandom_range(0, 15)));
              end else if (corner && k == 0 && b == 8'hED) begin
                burst.push_back(8'hA0 | 8'($urandom_range(0, 31)));
              end else begin
                burst.push_back(8'h80 | 8'($urandom_range(0, 63)));
              end
            end
            // A broken sequence ends on a byte that is no continuation.
            if (kind == BURST_BROKEN) begin
              do begin
                b = 8'($urandom_range(0, 255));
              end while ((b & 8'hC0) == 8'h80);
              burst.push_back(b);
            end
          end
        endcase

        foreach (burst[i]) begin
          eos = ($urandom_range(0, 9) == 0);
          send_byte(burst[i], eos, 1'b0, "");
          if (burst[i] != 8'h00 || eos) sent++;
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
